// File: hw/rtl/tfr_pkg.sv
// tfr_pkg: beat types, format codes, half-float class codes and stage enables
// shared by the texel converter. No dependencies.
package tfr_pkg;

    localparam logic [2:0] FMT_GRAY8   = 3'd0;
    localparam logic [2:0] FMT_BGRA8   = 3'd1;
    localparam logic [2:0] FMT_RGBA16  = 3'd2;
    localparam logic [2:0] FMT_RGBA16F = 3'd3;

    // Class of a half-float channel after decode
    localparam logic [1:0] CLS_ZERO = 2'd0;
    localparam logic [1:0] CLS_SAT  = 2'd1;
    localparam logic [1:0] CLS_CALC = 2'd2;

    localparam logic [7:0] UNORM_MAX = 8'd255;

    typedef struct packed {
        logic [2:0]  format;
        logic [15:0] word0;
        logic [15:0] word1;
        logic [15:0] word2;
        logic [15:0] word3;
    } in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       unsupported;
    } out_t;

    // Load enables for the decode, multiply and round stages
    typedef struct packed {
        logic b;
        logic c;
        logic d;
    } stage_en_t;

endpackage

// File: hw/rtl/tfr_half_chan.sv
// tfr_half_chan: three-stage half-float to unorm8 datapath for one channel
// (decode, scale by 255, round and clamp). Depends on tfr_pkg.
module tfr_half_chan
(
    input  logic                clk,
    input  tfr_pkg::stage_en_t  en,
    input  logic [15:0]         word,
    output logic [7:0]          value
);

    logic        sgn;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [1:0]  cls_next;
    logic [10:0] sig_next;
    logic [4:0]  shm1_next;

    logic [1:0]  cls_b_reg;
    logic [10:0] sig_b_reg;
    logic [4:0]  shm1_b_reg;

    logic [1:0]  cls_c_reg;
    logic [18:0] prod_c_reg;
    logic [4:0]  shm1_c_reg;

    logic [18:0] shifted;
    logic [9:0]  rounded;
    logic [7:0]  val_next;
    logic [7:0]  val_d_reg;

    assign sgn = word[15];
    assign ex  = word[14:10];
    assign man = word[9:0];

    always_comb
    begin
        if (ex == 5'h1F)
        begin
            cls_next = (man != 10'd0 || sgn) ? tfr_pkg::CLS_ZERO : tfr_pkg::CLS_SAT;
        end
        else if (sgn)
        begin
            cls_next = tfr_pkg::CLS_ZERO;
        end
        else if (ex >= 5'd15)
        begin
            cls_next = tfr_pkg::CLS_SAT;
        end
        else
        begin
            cls_next = tfr_pkg::CLS_CALC;
        end
        // Subnormals scale like exponent one without the hidden bit
        sig_next  = {(ex != 5'd0), man};
        shm1_next = (ex == 5'd0) ? 5'd23 : 5'(5'd24 - ex);
    end

    always_ff @(posedge clk)
    begin
        if (en.b)
        begin
            cls_b_reg  <= cls_next;
            sig_b_reg  <= sig_next;
            shm1_b_reg <= shm1_next;
        end
        if (en.c)
        begin
            cls_c_reg  <= cls_b_reg;
            prod_c_reg <= 19'(sig_b_reg) * 19'd255;
            shm1_c_reg <= shm1_b_reg;
        end
        if (en.d)
        begin
            val_d_reg <= val_next;
        end
    end

    // Shift one bit short, then add one and drop it: round half up
    assign shifted = prod_c_reg >> shm1_c_reg;
    assign rounded = 10'(shifted[9:0] + 10'd1) >> 1;

    always_comb
    begin
        case (cls_c_reg)
            tfr_pkg::CLS_SAT:  val_next = tfr_pkg::UNORM_MAX;
            tfr_pkg::CLS_CALC: val_next = (rounded > 10'd255) ? tfr_pkg::UNORM_MAX
                                                              : rounded[7:0];
            default:           val_next = 8'd0;
        endcase
    end

    assign value = val_d_reg;

endmodule

// File: hw/rtl/texel_format_to_rgba8.sv
// texel_format_to_rgba8: top level, input register, byte-format swizzle,
// pipeline flow control and four half-float channel datapaths.
// Depends on tfr_pkg and tfr_half_chan.
//
//   channel | direction | handshake          | payload
//   src     | in        | src_valid/src_stall | tfr_pkg::in_t  (format, word0..word3)
//   dst     | out       | dst_valid/dst_stall | tfr_pkg::out_t (red..alpha, unsupported)
//
// One texel per cycle while dst is not stalled.
// The four register stages are input, decode, multiply by 255, round and clamp.
// Each stage loads when it is empty or the stage after it moves, so a bubble
// is filled even while dst is stalled. rst_n clears the valid bits only.
module texel_format_to_rgba8
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_valid,
    output logic           src_stall,
    input  tfr_pkg::in_t   src_data,
    output logic           dst_valid,
    input  logic           dst_stall,
    output tfr_pkg::out_t  dst_data
);

    logic valid_a_reg, valid_b_reg, valid_c_reg, valid_d_reg;
    logic ready_a, ready_b, ready_c, ready_d;
    logic load_a;
    tfr_pkg::stage_en_t en;

    tfr_pkg::in_t in_a_reg;

    logic [7:0] byte_r_next, byte_g_next, byte_b_next, byte_a_next;
    logic       half_next, bad_next;

    logic [7:0] byte_r_b_reg, byte_g_b_reg, byte_b_b_reg, byte_a_b_reg;
    logic       half_b_reg, bad_b_reg;
    logic [7:0] byte_r_c_reg, byte_g_c_reg, byte_b_c_reg, byte_a_c_reg;
    logic       half_c_reg, bad_c_reg;
    logic [7:0] byte_r_d_reg, byte_g_d_reg, byte_b_d_reg, byte_a_d_reg;
    logic       half_d_reg, bad_d_reg;

    logic [7:0] half_r, half_g, half_b, half_a;

    // Flow control: a stage advances when empty or its successor advances
    assign ready_d = !valid_d_reg || !dst_stall;
    assign ready_c = !valid_c_reg || ready_d;
    assign ready_b = !valid_b_reg || ready_c;
    assign ready_a = !valid_a_reg || ready_b;

    assign src_stall = !ready_a;
    assign load_a    = src_valid && ready_a;
    assign en.b      = valid_a_reg && ready_b;
    assign en.c      = valid_b_reg && ready_c;
    assign en.d      = valid_c_reg && ready_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end
        else
        begin
            if (ready_a) valid_a_reg <= src_valid;
            if (ready_b) valid_b_reg <= valid_a_reg;
            if (ready_c) valid_c_reg <= valid_b_reg;
            if (ready_d) valid_d_reg <= valid_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            in_a_reg <= src_data;
        end
    end

    // Byte formats resolve here; the half-float path runs in the channel units
    always_comb
    begin
        byte_r_next = 8'd0;
        byte_g_next = 8'd0;
        byte_b_next = 8'd0;
        byte_a_next = 8'd0;
        half_next   = 1'b0;
        bad_next    = 1'b0;
        case (in_a_reg.format)
            tfr_pkg::FMT_GRAY8:
            begin
                byte_r_next = in_a_reg.word0[7:0];
                byte_g_next = in_a_reg.word0[7:0];
                byte_b_next = in_a_reg.word0[7:0];
                byte_a_next = tfr_pkg::UNORM_MAX;
            end
            tfr_pkg::FMT_BGRA8:
            begin
                byte_b_next = in_a_reg.word0[7:0];
                byte_g_next = in_a_reg.word1[7:0];
                byte_r_next = in_a_reg.word2[7:0];
                byte_a_next = in_a_reg.word3[7:0];
            end
            tfr_pkg::FMT_RGBA16:
            begin
                byte_r_next = in_a_reg.word0[15:8];
                byte_g_next = in_a_reg.word1[15:8];
                byte_b_next = in_a_reg.word2[15:8];
                byte_a_next = in_a_reg.word3[15:8];
            end
            tfr_pkg::FMT_RGBA16F:
            begin
                half_next = 1'b1;
            end
            default:
            begin
                bad_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.b)
        begin
            byte_r_b_reg <= byte_r_next;
            byte_g_b_reg <= byte_g_next;
            byte_b_b_reg <= byte_b_next;
            byte_a_b_reg <= byte_a_next;
            half_b_reg   <= half_next;
            bad_b_reg    <= bad_next;
        end
        if (en.c)
        begin
            byte_r_c_reg <= byte_r_b_reg;
            byte_g_c_reg <= byte_g_b_reg;
            byte_b_c_reg <= byte_b_b_reg;
            byte_a_c_reg <= byte_a_b_reg;
            half_c_reg   <= half_b_reg;
            bad_c_reg    <= bad_b_reg;
        end
        if (en.d)
        begin
            byte_r_d_reg <= byte_r_c_reg;
            byte_g_d_reg <= byte_g_c_reg;
            byte_b_d_reg <= byte_b_c_reg;
            byte_a_d_reg <= byte_a_c_reg;
            half_d_reg   <= half_c_reg;
            bad_d_reg    <= bad_c_reg;
        end
    end

    tfr_half_chan u_chan_r
    (
        .clk   (clk),
        .en    (en),
        .word  (in_a_reg.word0),
        .value (half_r)
    );

    tfr_half_chan u_chan_g
    (
        .clk   (clk),
        .en    (en),
        .word  (in_a_reg.word1),
        .value (half_g)
    );

    tfr_half_chan u_chan_b
    (
        .clk   (clk),
        .en    (en),
        .word  (in_a_reg.word2),
        .value (half_b)
    );

    tfr_half_chan u_chan_a
    (
        .clk   (clk),
        .en    (en),
        .word  (in_a_reg.word3),
        .value (half_a)
    );

    assign dst_valid            = valid_d_reg;
    assign dst_data.red         = half_d_reg ? half_r : byte_r_d_reg;
    assign dst_data.green       = half_d_reg ? half_g : byte_g_d_reg;
    assign dst_data.blue        = half_d_reg ? half_b : byte_b_d_reg;
    assign dst_data.alpha       = half_d_reg ? half_a : byte_a_d_reg;
    assign dst_data.unsupported = bad_d_reg;

endmodule

// File: hw/rtl/tfr_check.sv
// tfr_check: port-level checks for texel_format_to_rgba8, bound to the top level.
// Depends on tfr_pkg.
module tfr_check
(
    input logic           clk,
    input logic           rst_n,
    input logic           src_valid,
    input logic           src_stall,
    input tfr_pkg::in_t   src_data,
    input logic           dst_valid,
    input logic           dst_stall,
    input tfr_pkg::out_t  dst_data
);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
    else $error("dst beat changed under stall");

    // An empty output stage means every stage can advance
    assert property (@(posedge clk) disable iff (!rst_n)
        !dst_valid |-> !src_stall)
    else $error("src stalled with empty output stage");

    // Unsupported formats carry all-zero channels
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_data.unsupported |->
            dst_data.red == 8'd0 && dst_data.green == 8'd0 &&
            dst_data.blue == 8'd0 && dst_data.alpha == 8'd0)
    else $error("unsupported beat with nonzero channels");

    // With no stall downstream, an accepted beat moves through the input, decode, multiply and round stages to dst
    assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall && !dst_stall ##1 !dst_stall ##1 !dst_stall
            ##1 !dst_stall |=> dst_valid)
    else $error("accepted beat did not reach dst in four cycles");

endmodule

bind texel_format_to_rgba8 tfr_check u_tfr_check (.*);
